@@ design/random_word_generator_with_range_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the random word generator
// Concurrent checks that compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef RANDOM_WORD_GENERATOR_WITH_RANGE_UNIT_DEFINES_SVH
`define RANDOM_WORD_GENERATOR_WITH_RANGE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RWGR_ASSERT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rwgr assertion failed");
// next-cycle implication
`define RWGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rwgr assertion failed");
`else
`define RWGR_ASSERT(lbl, clk, rstn, ante, cons)
`define RWGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/rwgr_pkg.sv @@
// ----------------------------------------------------------------------------
// rwgr_pkg
// Types, constants and helper functions of the random word generator.
// ----------------------------------------------------------------------------
package rwgr_pkg;

	// generator constants
	localparam logic [63:0] LCG_MUL = 64'd2862933555777941757;
	localparam logic [63:0] LCG_ADD = 64'd7046029254386353087;
	localparam logic [31:0] MWC_MUL = 32'd4294957665;
	localparam logic [63:0] XS_INIT = 64'd4101842887655102017;

	// advance sequencer steps
	localparam logic [2:0] STEP_P0  = 3'd0;
	localparam logic [2:0] STEP_P1  = 3'd1;
	localparam logic [2:0] STEP_P2  = 3'd2;
	localparam logic [2:0] STEP_P3  = 3'd3;
	localparam logic [2:0] STEP_UPD = 3'd4;

	// advance phases of one draw
	localparam logic [1:0] PH_SEED_XS  = 2'd0;
	localparam logic [1:0] PH_SEED_MWC = 2'd1;
	localparam logic [1:0] PH_DRAW     = 2'd2;

	// remainder unit
	localparam int             MOD_CNT_W  = 6;
	localparam logic [MOD_CNT_W-1:0] MOD_CNT_LAST = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_ADV,
		ST_MIX,
		ST_MOD,
		ST_FIN
	} rwgr_state_t;

	typedef struct packed {
		logic signed [31:0] range_first;
		logic signed [31:0] range_last;
	} rwgr_req_t;

	typedef struct packed {
		logic [63:0]        raw_word;
		logic signed [31:0] ranged_value;
		logic               range_error;
	} rwgr_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rwgr_mod_stat_t;

	function automatic logic [63:0] xorshift_step(input logic [63:0] x);
		logic [63:0] t;
		t = x ^ (x >> 17);
		t = t ^ (t << 31);
		t = t ^ (t >> 8);
		return t;
	endfunction

	function automatic logic [63:0] mix_word(input logic [63:0] lcg, input logic [63:0] xs,
			input logic [63:0] mwc);
		logic [63:0] t;
		t = lcg ^ (lcg << 21);
		t = t ^ (t >> 35);
		t = t ^ (t << 4);
		return (t + xs) ^ mwc;
	endfunction

endpackage

@@ design/rwgr_mod.sv @@
// ----------------------------------------------------------------------------
// rwgr_mod
// Restoring remainder unit: 64-bit dividend by 33-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`include "random_word_generator_with_range_unit_defines.svh"

module rwgr_mod (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [63:0]             dividend,
	input  logic [32:0]             divisor,
	output rwgr_pkg::rwgr_mod_stat_t stat,
	output logic [31:0]             remainder
);

	logic                           busy_q;
	logic                           done_q;
	logic [rwgr_pkg::MOD_CNT_W-1:0] cnt_q;
	logic [63:0]                    dvd_q;
	logic [32:0]                    dvs_q;
	logic [31:0]                    rem_q;
	logic [32:0]                    trial;
	logic [32:0]                    diff;
	logic [31:0]                    rem_next;

	// rem stays below the divisor (<= 2^32), so 32 bits hold it
	assign trial    = {rem_q, dvd_q[63]};
	assign diff     = trial - dvs_q;
	assign rem_next = (trial >= dvs_q) ? diff[31:0] : trial[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rwgr_pkg::MOD_CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

	`RWGR_ASSERT(a_mod_no_restart, clk, arst_n, start, !busy_q)
	`RWGR_ASSERT(a_mod_done_idle, clk, arst_n, done_q, !busy_q)
	`RWGR_ASSERT_NEXT(a_mod_last_done, clk, arst_n, busy_q && !start && cnt_q == rwgr_pkg::MOD_CNT_LAST, done_q && !busy_q)

endmodule

@@ design/random_word_generator_with_range_unit.sv @@
// ----------------------------------------------------------------------------
// random_word_generator_with_range_unit
// Combined LCG / xorshift / multiply-with-carry generator with range mapping.
// ----------------------------------------------------------------------------
// Usage:
//  - req (range_first, range_last) is taken on req_valid & req_ready. Each
//    transaction draws one 64-bit raw word and maps it into the inclusive
//    range as first + word mod (last - first + 1). last < first flags
//    range_error and returns first; the generator still advances.
//  - rsp carries raw_word, ranged_value, range_error; one rsp per req.
//  - cfg_we writes the 64-bit seed from cfg_data; the next draw reseeds.
//  - A draw runs the advance, mix and remainder steps in order; the first
//    draw after reset or a seed write also seeds (two extra advances).
//    Each advance steps through P0..P3 and UPD on one shared 32x32
//    multiplier; the remainder unit works through all 64 dividend bits,
//    one quotient bit per cycle, and one transaction runs at a time.
//  - req_ready is high only while idle. A finished rsp sits in an output
//    register, so a new req can be taken while the receiver stalls; a
//    second result then waits in the last step until the register frees.
//  - Reset clears the seed, the seeded flag and all control state.
// ----------------------------------------------------------------------------
`include "random_word_generator_with_range_unit_defines.svh"

module random_word_generator_with_range_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rwgr_pkg::rwgr_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rwgr_pkg::rwgr_rsp_t rsp,
	input  logic                cfg_we,
	input  logic [63:0]         cfg_data
);

	rwgr_pkg::rwgr_state_t state_q, state_d;

	// control
	logic [2:0]  step_q;
	logic [1:0]  phase_q;
	logic        seeded_q;
	logic [63:0] seed_q;
	logic        rsp_valid_q;

	// datapath
	rwgr_pkg::rwgr_req_t req_q;
	rwgr_pkg::rwgr_rsp_t rsp_q;
	logic [63:0] lcg_q;
	logic [63:0] xs_q;
	logic [63:0] carry_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [63:0] word_q;
	logic        err_q;

	// sequencer decodes
	logic do_seed;
	logic do_adv;
	logic do_mix;
	logic do_load;
	logic req_acc;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_prod;
	logic [63:0] xs_new;
	logic [63:0] carry_new;
	logic [63:0] mixed;
	logic        range_bad;
	logic [32:0] span;
	logic [31:0] mod_rem;
	rwgr_pkg::rwgr_mod_stat_t mod_stat;

	assign req_acc = req_valid && req_ready;

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			rwgr_pkg::ST_IDLE: begin
				if (req_valid)
					state_d = seeded_q ? rwgr_pkg::ST_ADV : rwgr_pkg::ST_SEED;
			end
			rwgr_pkg::ST_SEED: state_d = rwgr_pkg::ST_ADV;
			rwgr_pkg::ST_ADV: begin
				if (step_q == rwgr_pkg::STEP_UPD && phase_q == rwgr_pkg::PH_DRAW)
					state_d = rwgr_pkg::ST_MIX;
			end
			rwgr_pkg::ST_MIX: state_d = rwgr_pkg::ST_MOD;
			rwgr_pkg::ST_MOD: begin
				if (mod_stat.done)
					state_d = rwgr_pkg::ST_FIN;
			end
			rwgr_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp_ready)
					state_d = rwgr_pkg::ST_IDLE;
			end
			default: state_d = rwgr_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// state decodes
	// ------------------------------------------------------------------
	always_comb begin
		req_ready = 1'b0;
		do_seed   = 1'b0;
		do_adv    = 1'b0;
		do_mix    = 1'b0;
		do_load   = 1'b0;
		case (state_q)
			rwgr_pkg::ST_IDLE: req_ready = 1'b1;
			rwgr_pkg::ST_SEED: do_seed   = 1'b1;
			rwgr_pkg::ST_ADV:  do_adv    = 1'b1;
			rwgr_pkg::ST_MIX:  do_mix    = 1'b1;
			rwgr_pkg::ST_MOD:  ;
			rwgr_pkg::ST_FIN:  do_load   = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rwgr_pkg::ST_IDLE;
			step_q      <= rwgr_pkg::STEP_P0;
			phase_q     <= rwgr_pkg::PH_DRAW;
			seeded_q    <= 1'b0;
			seed_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (req_acc) begin
				step_q  <= rwgr_pkg::STEP_P0;
				phase_q <= seeded_q ? rwgr_pkg::PH_DRAW : rwgr_pkg::PH_SEED_XS;
			end else if (do_adv) begin
				if (step_q == rwgr_pkg::STEP_UPD) begin
					step_q <= rwgr_pkg::STEP_P0;
					if (phase_q != rwgr_pkg::PH_DRAW)
						phase_q <= phase_q + 2'd1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end

			// a seed write forces a reseed on the next draw
			if (cfg_we) begin
				seed_q   <= cfg_data;
				seeded_q <= 1'b0;
			end else if (do_seed) begin
				seeded_q <= 1'b1;
			end

			if (do_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// shared multiplier: low 64 bits of lcg * LCG_MUL from three 32x32
	// partial products, then the 32x32 multiply-with-carry product
	// ------------------------------------------------------------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			rwgr_pkg::STEP_P0: begin
				mul_a = lcg_q[31:0];
				mul_b = rwgr_pkg::LCG_MUL[31:0];
			end
			rwgr_pkg::STEP_P1: begin
				mul_a = lcg_q[31:0];
				mul_b = rwgr_pkg::LCG_MUL[63:32];
			end
			rwgr_pkg::STEP_P2: begin
				mul_a = lcg_q[63:32];
				mul_b = rwgr_pkg::LCG_MUL[31:0];
			end
			rwgr_pkg::STEP_P3: begin
				mul_a = carry_q[31:0];
				mul_b = rwgr_pkg::MWC_MUL;
			end
			default: ;
		endcase
	end

	assign mul_prod  = mul_a * mul_b;
	assign xs_new    = rwgr_pkg::xorshift_step(xs_q);
	// prod_q holds the carry product in the update step
	assign carry_new = prod_q + {32'd0, carry_q[63:32]};
	assign mixed     = rwgr_pkg::mix_word(lcg_q, xs_q, carry_q);

	// span = last - first + 1 in 33 bits; garbage when the range is inverted
	assign range_bad = $signed(req_q.range_last) < $signed(req_q.range_first);
	assign span      = {req_q.range_last[31], req_q.range_last}
	                 - {req_q.range_first[31], req_q.range_first} + 33'd1;

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_acc)
			req_q <= req;

		if (do_seed) begin
			xs_q    <= rwgr_pkg::XS_INIT;
			carry_q <= 64'd1;
			lcg_q   <= seed_q ^ rwgr_pkg::XS_INIT;
		end

		if (do_adv) begin
			prod_q <= mul_prod;
			case (step_q)
				rwgr_pkg::STEP_P1: acc_q <= prod_q + rwgr_pkg::LCG_ADD;
				rwgr_pkg::STEP_P2: acc_q <= acc_q + {prod_q[31:0], 32'd0};
				rwgr_pkg::STEP_P3: acc_q <= acc_q + {prod_q[31:0], 32'd0};
				rwgr_pkg::STEP_UPD: begin
					lcg_q <= acc_q;
					// seeding copies one sub-generator into the next
					case (phase_q)
						rwgr_pkg::PH_SEED_XS: begin
							xs_q    <= acc_q;
							carry_q <= carry_new;
						end
						rwgr_pkg::PH_SEED_MWC: begin
							xs_q    <= xs_new;
							carry_q <= xs_new;
						end
						default: begin
							xs_q    <= xs_new;
							carry_q <= carry_new;
						end
					endcase
				end
				default: ;
			endcase
		end

		if (do_mix) begin
			word_q <= mixed;
			err_q  <= range_bad;
		end

		if (do_load) begin
			rsp_q.raw_word     <= word_q;
			rsp_q.range_error  <= err_q;
			rsp_q.ranged_value <= err_q ? req_q.range_first
			                            : req_q.range_first + mod_rem;
		end
	end

	rwgr_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (do_mix),
		.dividend  (mixed),
		.divisor   (span),
		.stat      (mod_stat),
		.remainder (mod_rem)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RWGR_ASSERT(a_done_in_mod, clk, arst_n, mod_stat.done, state_q == rwgr_pkg::ST_MOD)
	`RWGR_ASSERT_NEXT(a_seeded_after_seed, clk, arst_n, state_q == rwgr_pkg::ST_SEED, seeded_q)
	`RWGR_ASSERT(a_step_range, clk, arst_n, state_q == rwgr_pkg::ST_ADV, step_q <= rwgr_pkg::STEP_UPD)
	`RWGR_ASSERT_NEXT(a_rsp_from_fin, clk, arst_n, state_q != rwgr_pkg::ST_FIN && !rsp_valid_q, !rsp_valid_q)

endmodule
